FILE: rtl/core/cfb_pkg.sv
// Shared types, codes and CRC helper for the command frame builder.
package cfb_pkg;

  // Input command codes.
  localparam logic [1:0] CMD_NAME = 2'd0;
  localparam logic [1:0] CMD_ARG  = 2'd1;
  localparam logic [1:0] CMD_END  = 2'd2;

  // Front-side frame phase codes.
  localparam logic [1:0] PHASE_IDLE = 2'd0;
  localparam logic [1:0] PHASE_NAME = 2'd1;
  localparam logic [1:0] PHASE_ARGS = 2'd2;

  // Marker characters.
  localparam logic [7:0] CH_LBRACK = 8'h5B;  // '['
  localparam logic [7:0] CH_RBRACK = 8'h5D;  // ']'
  localparam logic [7:0] CH_HEAD   = 8'h2F;  // '/'
  localparam logic [7:0] CH_MID    = 8'h5E;  // '^'
  localparam logic [7:0] CH_TAIL   = 8'h5F;  // '_'
  localparam logic [7:0] CH_CLOSE  = 8'h3E;  // '>'

  localparam logic [15:0] SEED_RESET = 16'h00FF;

  // Descriptor queue between the front and the back.
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  // One classified word: which pieces of the frame the back must emit.
  typedef struct packed {
    logic       open;      // head marker first
    logic       mid;       // middle marker
    logic       has_byte;  // pass the data byte through
    logic       is_end;    // tail marker, CRC and closing marker
    logic [7:0] data;
  } desc_t;

  // One byte of the reflected CCITT CRC16 (polynomial 0x8408).
  function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] d);
    logic [7:0] x;
    begin
      x = d ^ c[7:0];
      x = x ^ {x[3:0], 4'b0000};
      crc_step = {x, c[15:8]} ^ {12'h000, x[7:4]} ^ {5'b00000, x, 3'b000};
    end
  endfunction

endpackage

FILE: rtl/core/cfb_front.sv
// Front end: accepts input words, tracks the frame phase and classifies each word.
module cfb_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [1:0]    in_command,
  input  logic [7:0]    in_data_byte,
  input  logic          q_full,
  output logic          q_push,
  output cfb_pkg::desc_t q_desc
);
  import cfb_pkg::*;

  logic [1:0] phase_r, phase_nxt;
  logic       accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    phase_nxt       = phase_r;
    q_push          = 1'b0;
    q_desc.open     = (phase_r != PHASE_NAME) && (phase_r != PHASE_ARGS);
    q_desc.mid      = 1'b0;
    q_desc.has_byte = 1'b0;
    q_desc.is_end   = 1'b0;
    q_desc.data     = in_data_byte;
    if (accept) begin
      unique case (in_command)
        CMD_NAME: begin
          q_push          = 1'b1;
          q_desc.has_byte = 1'b1;
          if (phase_r != PHASE_ARGS) phase_nxt = PHASE_NAME;
        end
        CMD_ARG: begin
          q_push          = 1'b1;
          q_desc.has_byte = 1'b1;
          q_desc.mid      = (phase_r != PHASE_ARGS);
          phase_nxt       = PHASE_ARGS;
        end
        CMD_END: begin
          q_push        = 1'b1;
          q_desc.is_end = 1'b1;
          q_desc.mid    = (phase_r != PHASE_ARGS);
          phase_nxt     = PHASE_IDLE;
        end
        default: begin
          // Unused command code: dropped without effect.
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PHASE_IDLE;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  a_end_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_command == CMD_END) |=> (phase_r == PHASE_IDLE))
    else $error("frame phase not idle after end of frame");

  a_open_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && q_desc.open) |-> (phase_r == PHASE_IDLE))
    else $error("head marker requested inside an open frame");
endmodule

FILE: rtl/core/cfb_queue.sv
// Short descriptor queue that decouples the front end from the byte sequencer.
module cfb_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  cfb_pkg::desc_t push_desc,
  output logic           full,
  output logic           head_valid,
  output cfb_pkg::desc_t head_desc,
  input  logic           pop
);
  import cfb_pkg::*;

  desc_t           slot_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_AW:0]   count_r, count_nxt;

  assign full       = (count_r == (Q_AW+1)'(Q_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_desc  = slot_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_desc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("pop from an empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (Q_AW+1)'(Q_DEPTH))
    else $error("queue count beyond depth");
endmodule

FILE: rtl/core/cfb_back.sv
// Back end: walks each descriptor one output byte per cycle while out_stall is low and keeps the running CRC.
module cfb_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [15:0]    seed,
  input  logic           q_valid,
  input  cfb_pkg::desc_t q_head,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     out_byte,
  output logic           out_frame_end
);
  import cfb_pkg::*;

  typedef enum logic [2:0] {
    SEG_FIRST, SEG_HEAD, SEG_MID, SEG_DATA, SEG_TAIL, SEG_CRCL, SEG_CRCH, SEG_CLOSE
  } seg_t;

  seg_t        seg_r, seg_nxt, cur_seg, after_seg;
  logic [1:0]  pos_r, pos_nxt;
  logic [15:0] crc_r, crc_nxt, crc_base;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_byte_r, out_byte_nxt;
  logic        out_end_r, out_end_nxt;
  logic        advance, emit, is_marker, seg_last, fold, desc_done;
  logic [7:0]  mid_char, cur_byte;

  // Segment that follows a given one within a descriptor; SEG_FIRST means done.
  function automatic seg_t next_seg(input seg_t s, input desc_t d);
    begin
      next_seg = SEG_FIRST;
      unique case (s)
        SEG_FIRST: next_seg = d.open ? SEG_HEAD : d.mid ? SEG_MID :
                              d.has_byte ? SEG_DATA : d.is_end ? SEG_TAIL : SEG_FIRST;
        SEG_HEAD:  next_seg = d.mid ? SEG_MID : d.has_byte ? SEG_DATA :
                              d.is_end ? SEG_TAIL : SEG_FIRST;
        SEG_MID:   next_seg = d.has_byte ? SEG_DATA : d.is_end ? SEG_TAIL : SEG_FIRST;
        SEG_DATA:  next_seg = d.is_end ? SEG_TAIL : SEG_FIRST;
        SEG_TAIL:  next_seg = SEG_CRCL;
        SEG_CRCL:  next_seg = SEG_CRCH;
        SEG_CRCH:  next_seg = SEG_CLOSE;
        SEG_CLOSE: next_seg = SEG_FIRST;
        default:   next_seg = SEG_FIRST;
      endcase
    end
  endfunction

  assign advance = !out_valid_r || !out_stall;
  assign emit    = advance && q_valid;

  always_comb begin
    cur_seg   = (seg_r == SEG_FIRST) ? next_seg(SEG_FIRST, q_head) : seg_r;
    after_seg = next_seg(cur_seg, q_head);
    is_marker = (cur_seg == SEG_HEAD) || (cur_seg == SEG_MID) ||
                (cur_seg == SEG_TAIL) || (cur_seg == SEG_CLOSE);
    seg_last  = is_marker ? (pos_r == 2'd2) : 1'b1;
    fold      = (cur_seg == SEG_HEAD) || (cur_seg == SEG_MID) ||
                (cur_seg == SEG_DATA) || (cur_seg == SEG_TAIL);
    crc_base  = (cur_seg == SEG_HEAD && pos_r == 2'd0) ? seed : crc_r;

    mid_char = CH_HEAD;
    unique case (cur_seg)
      SEG_MID:   mid_char = CH_MID;
      SEG_TAIL:  mid_char = CH_TAIL;
      SEG_CLOSE: mid_char = CH_CLOSE;
      default:   mid_char = CH_HEAD;
    endcase

    cur_byte = 8'h00;
    unique case (cur_seg)
      SEG_HEAD, SEG_MID, SEG_TAIL, SEG_CLOSE: begin
        unique case (pos_r)
          2'd0:    cur_byte = CH_LBRACK;
          2'd1:    cur_byte = mid_char;
          default: cur_byte = CH_RBRACK;
        endcase
      end
      SEG_DATA: cur_byte = q_head.data;
      SEG_CRCL: cur_byte = crc_r[7:0];
      SEG_CRCH: cur_byte = crc_r[15:8];
      default:  cur_byte = 8'h00;
    endcase

    desc_done = seg_last && (after_seg == SEG_FIRST);
    q_pop     = emit && desc_done;

    seg_nxt       = seg_r;
    pos_nxt       = pos_r;
    crc_nxt       = crc_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_end_nxt   = out_end_r;
    if (advance) begin
      out_valid_nxt = emit;
      if (emit) begin
        out_byte_nxt = cur_byte;
        out_end_nxt  = (cur_seg == SEG_CLOSE) && (pos_r == 2'd2);
        if (fold) crc_nxt = crc_step(crc_base, cur_byte);
        if (!seg_last) begin
          seg_nxt = cur_seg;
          pos_nxt = pos_r + 2'd1;
        end else begin
          seg_nxt = after_seg;
          pos_nxt = 2'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r       <= SEG_FIRST;
      pos_r       <= 2'd0;
      crc_r       <= 16'h0000;
      out_valid_r <= 1'b0;
      out_end_r   <= 1'b0;
      out_byte_r  <= 8'h00;
    end else begin
      seg_r       <= seg_nxt;
      pos_r       <= pos_nxt;
      crc_r       <= crc_nxt;
      out_valid_r <= out_valid_nxt;
      out_end_r   <= out_end_nxt;
      out_byte_r  <= out_byte_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_byte      = out_byte_r;
  assign out_frame_end = out_end_r;

  a_end_is_bracket: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_end_r) |-> (out_byte_r == CH_RBRACK))
    else $error("frame end flagged on a byte other than the closing bracket");

  a_crc_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && (cur_seg == SEG_CRCL)) |=> $stable(crc_r))
    else $error("CRC changed while its bytes were sent");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r != 2'd3)
    else $error("marker position out of range");
endmodule

FILE: rtl/core/command_frame_builder_crc16.sv
// Top level of the command frame builder with reflected CCITT CRC16.
//
// Each input word is a command-name byte, an argument byte or an end-of-frame mark; the
// block turns the stream into framed text: "[/]" before the first byte of a frame, "[^]"
// before the first argument byte (or at end of frame if no argument came), and at end of
// frame "[_]", the CRC low and high bytes and "[>]", with out_frame_end set on the final
// ']'. The CRC is loaded from the crc_seed register (reset 0x00FF) when "[/]" starts and
// covers every byte up to and including "[_]". While out_stall is low, the output stream runs at
// one byte per cycle, limited by the back-end sequencer, which moves one byte per cycle into the
// output register. A name or argument word inside an open frame costs only its data byte;
// opening a frame adds "[/]", the first argument adds "[^]", and an end mark costs "[_]", the
// CRC bytes and "[>]", plus "[^]" if owed. A four-word queue sits between the front end that
// classifies words and the sequencer, so input words keep being taken while markers go out.
// Write crc_seed only while the block is idle; a new value applies at the next frame start.
module command_frame_builder_crc16 (
  input  logic        clk,
  input  logic        rst_n,
  // Input word channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [7:0]  in_data_byte,
  // Output word channel.
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_frame_end,
  // Configuration write channel for crc_seed.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_crc_seed
);
  import cfb_pkg::*;

  logic [15:0] seed_r;
  logic        q_full, q_push, q_valid, q_pop;
  desc_t       q_desc, q_head;

  // The seed register always takes a write.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= SEED_RESET;
    end else if (cfg_valid && cfg_ready) begin
      seed_r <= cfg_crc_seed;
    end
  end

  cfb_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_command   (in_command),
    .in_data_byte (in_data_byte),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_desc       (q_desc)
  );

  cfb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_desc  (q_desc),
    .full       (q_full),
    .head_valid (q_valid),
    .head_desc  (q_head),
    .pop        (q_pop)
  );

  cfb_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .seed          (seed_r),
    .q_valid       (q_valid),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_frame_end (out_frame_end)
  );
endmodule
